// ===== rtl/core/dsfl_pkg.sv =====
// shared widths, codes and controller/datapath interface types for the slot allocator
package dsfl_pkg;

    localparam int SLOT_W    = 10;
    localparam int PERS_W    = 11;
    localparam int TOTAL_W   = 17;
    localparam int STRIDE_W  = 13;
    localparam int ADDR_W    = 64;
    localparam int HEAPS_W   = 2;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int IDX_W     = 17;
    localparam int QUO_W     = 17;
    localparam int SPAN_W    = STRIDE_W + TOTAL_W;
    localparam int PROD_W    = SLOT_W + STRIDE_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [REQ_W-1:0] REQ_ALLOC    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE_IDX = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE_CPU = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FREE_GPU = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_BASE1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GPU_BASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAPS      = 3'd6;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NOOP       = 3'd1,
        ST_EXHAUSTED  = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_RANGE      = 3'd4,
        ST_BAD_HANDLE = 3'd5,
        ST_TWO_HEAPS  = 3'd6
    } t_status;

    typedef struct packed {
        logic    load;
        logic    mem_rd;
        logic    alloc_take;
        logic    off_calc;
        logic    div_start;
        logic    idx_from_div;
        logic    push;
        logic    finish;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             exhausted;
        logic             slot_none;
        logic             two_heaps;
        logic             addr_zero;
        logic             handle_bad;
        logic             over_span;
        logic             div_done;
        logic             rem_nonzero;
        logic             idx_over;
        logic             count_zero;
    } t_dp_stat;

endpackage

// ===== rtl/core/dsfl_div.sv =====
// bit-serial restoring divider that turns a handle offset into a slot index
module dsfl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dsfl_pkg::SPAN_W-1:0]   i_dividend,
    input  logic [dsfl_pkg::STRIDE_W-1:0] i_divisor,
    output logic                          o_done,
    output logic [dsfl_pkg::QUO_W-1:0]    o_quotient,
    output logic                          o_rem_nonzero
);

    logic [dsfl_pkg::STRIDE_W-1:0]  r_rem;
    logic [dsfl_pkg::QUO_W-1:0]     r_quo;
    logic [dsfl_pkg::STRIDE_W-1:0]  r_div;
    logic [dsfl_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [dsfl_pkg::STRIDE_W:0] w_trial;
    logic [dsfl_pkg::STRIDE_W:0] w_diff;
    logic                        w_ge;

    assign w_trial = {r_rem, r_quo[dsfl_pkg::QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + dsfl_pkg::DIV_CNT_W'(1);
                if (r_cnt == dsfl_pkg::DIV_CNT_W'(dsfl_pkg::QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient is known to fit, so the top bits start below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[dsfl_pkg::SPAN_W-1:dsfl_pkg::QUO_W];
            r_quo <= i_dividend[dsfl_pkg::QUO_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[dsfl_pkg::STRIDE_W-1:0] : w_trial[dsfl_pkg::STRIDE_W-1:0];
            r_quo <= {r_quo[dsfl_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_done        = r_done;
    assign o_quotient    = r_quo;
    assign o_rem_nonzero = r_rem != '0;

endmodule

// ===== rtl/core/dsfl_datapath.sv =====
// datapath: config registers, free-slot stack memory, handle math and result registers
module dsfl_datapath #(
    parameter int MAX_SLOTS = 1024,
    parameter bit HEAP_PICK = 1'b0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dsfl_pkg::t_dp_cmd              i_cmd,
    output dsfl_pkg::t_dp_stat             o_stat,
    input  logic                           i_cfg_we,
    input  logic [dsfl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dsfl_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [dsfl_pkg::REQ_W-1:0]     i_req_type,
    input  logic [dsfl_pkg::SLOT_W-1:0]    i_slot_in,
    input  logic                           i_slot_none,
    input  logic [dsfl_pkg::ADDR_W-1:0]    i_handle_addr,
    output logic [dsfl_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [dsfl_pkg::ADDR_W-1:0]    o_handle_first,
    output logic [dsfl_pkg::ADDR_W-1:0]    o_handle_second,
    output logic [dsfl_pkg::STATUS_W-1:0]  o_status,
    output logic                           o_done
);

    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int MEM_AW = $clog2(MAX_SLOTS);

    logic [dsfl_pkg::PERS_W-1:0]   r_persistent;
    logic [dsfl_pkg::TOTAL_W-1:0]  r_total;
    logic [dsfl_pkg::STRIDE_W-1:0] r_stride;
    logic [dsfl_pkg::ADDR_W-1:0]   r_cpu_base0;
    logic [dsfl_pkg::ADDR_W-1:0]   r_cpu_base1;
    logic [dsfl_pkg::ADDR_W-1:0]   r_gpu_base;
    logic [dsfl_pkg::HEAPS_W-1:0]  r_heaps;

    logic [dsfl_pkg::REQ_W-1:0]    r_req;
    logic                          r_slot_none;
    logic [dsfl_pkg::ADDR_W-1:0]   r_addr;
    logic [dsfl_pkg::IDX_W-1:0]    r_idx;
    logic [dsfl_pkg::ADDR_W-1:0]   r_off;
    logic [dsfl_pkg::SPAN_W-1:0]   r_span;
    logic [dsfl_pkg::PROD_W-1:0]   r_prod;

    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              r_hw;

    logic [dsfl_pkg::SLOT_W-1:0]   r_mem [MAX_SLOTS];
    logic [dsfl_pkg::SLOT_W-1:0]   r_rd_data;
    logic [dsfl_pkg::SLOT_W-1:0]   r_rd_pos;
    logic                          r_rd_fresh;

    logic [dsfl_pkg::ADDR_W-1:0]   w_base;
    logic [dsfl_pkg::IDX_W-1:0]    w_limit;
    logic [dsfl_pkg::IDX_W-1:0]    w_count_ext;
    logic [CNT_W-1:0]              w_count_dec;
    logic [dsfl_pkg::SLOT_W-1:0]   w_take;
    logic [dsfl_pkg::ADDR_W-1:0]   w_prod_ext;
    logic                          w_div_done;
    logic [dsfl_pkg::QUO_W-1:0]    w_quotient;
    logic                          w_rem_nonzero;
    logic                          w_ok;
    logic                          w_alloc_ok;

    assign w_base = (r_req == dsfl_pkg::REQ_FREE_GPU) ? r_gpu_base :
                    (HEAP_PICK ? r_cpu_base1 : r_cpu_base0);
    assign w_limit = (dsfl_pkg::IDX_W'(r_persistent) < dsfl_pkg::IDX_W'(MAX_SLOTS)) ?
                     dsfl_pkg::IDX_W'(r_persistent) : dsfl_pkg::IDX_W'(MAX_SLOTS);
    assign w_count_ext = dsfl_pkg::IDX_W'(r_count);
    assign w_count_dec = r_count - CNT_W'(1);
    // unwritten entries at or above the high-water mark use their position as index
    assign w_take      = r_rd_fresh ? r_rd_pos : r_rd_data;
    assign w_prod_ext  = {{(dsfl_pkg::ADDR_W - dsfl_pkg::PROD_W){1'b0}}, r_prod};
    assign w_ok        = i_cmd.status == dsfl_pkg::ST_OK;
    assign w_alloc_ok  = w_ok && (r_req == dsfl_pkg::REQ_ALLOC);

    always_comb begin
        o_stat.req         = r_req;
        o_stat.exhausted   = w_count_ext >= w_limit;
        o_stat.slot_none   = r_slot_none;
        o_stat.two_heaps   = r_heaps[1];
        o_stat.addr_zero   = r_addr == '0;
        o_stat.handle_bad  = (r_stride == '0) || (r_addr < w_base);
        o_stat.over_span   = r_off >= {{(dsfl_pkg::ADDR_W - dsfl_pkg::SPAN_W){1'b0}}, r_span};
        o_stat.div_done    = w_div_done;
        o_stat.rem_nonzero = w_rem_nonzero;
        o_stat.idx_over    = r_idx >= w_limit;
        o_stat.count_zero  = r_count == '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_persistent <= dsfl_pkg::PERS_W'(1024);
            r_total      <= dsfl_pkg::TOTAL_W'(1024);
            r_stride     <= dsfl_pkg::STRIDE_W'(32);
            r_cpu_base0  <= '0;
            r_cpu_base1  <= '0;
            r_gpu_base   <= '0;
            r_heaps      <= dsfl_pkg::HEAPS_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dsfl_pkg::CFG_PERSISTENT: r_persistent <= i_cfg_data[dsfl_pkg::PERS_W-1:0];
                dsfl_pkg::CFG_TOTAL:      r_total      <= i_cfg_data[dsfl_pkg::TOTAL_W-1:0];
                dsfl_pkg::CFG_STRIDE:     r_stride     <= i_cfg_data[dsfl_pkg::STRIDE_W-1:0];
                dsfl_pkg::CFG_CPU_BASE0:  r_cpu_base0  <= i_cfg_data;
                dsfl_pkg::CFG_CPU_BASE1:  r_cpu_base1  <= i_cfg_data;
                dsfl_pkg::CFG_GPU_BASE:   r_gpu_base   <= i_cfg_data;
                dsfl_pkg::CFG_HEAPS:      r_heaps      <= i_cfg_data[dsfl_pkg::HEAPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // stack fill, high-water mark and the registered done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hw    <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= i_cmd.finish;
            if (i_cmd.alloc_take) begin
                r_count <= r_count + CNT_W'(1);
                if (r_count >= r_hw) begin
                    r_hw <= r_count + CNT_W'(1);
                end
            end else if (i_cmd.push) begin
                r_count <= w_count_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[w_count_dec[MEM_AW-1:0]] <= r_idx[dsfl_pkg::SLOT_W-1:0];
        end
        if (i_cmd.mem_rd) begin
            r_rd_data  <= r_mem[r_count[MEM_AW-1:0]];
            r_rd_pos   <= w_count_ext[dsfl_pkg::SLOT_W-1:0];
            r_rd_fresh <= r_count >= r_hw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req       <= i_req_type;
            r_slot_none <= i_slot_none;
            r_addr      <= i_handle_addr;
            r_idx       <= dsfl_pkg::IDX_W'(i_slot_in);
        end else if (i_cmd.alloc_take) begin
            r_idx <= dsfl_pkg::IDX_W'(w_take);
        end else if (i_cmd.idx_from_div) begin
            r_idx <= w_quotient;
        end
        if (i_cmd.alloc_take) begin
            r_prod <= {{dsfl_pkg::STRIDE_W{1'b0}}, w_take}
                    * {{dsfl_pkg::SLOT_W{1'b0}}, r_stride};
        end
        if (i_cmd.off_calc) begin
            r_off  <= r_addr - w_base;
            r_span <= {{dsfl_pkg::TOTAL_W{1'b0}}, r_stride}
                    * {{dsfl_pkg::STRIDE_W{1'b0}}, r_total};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status        <= i_cmd.status;
            o_slot_out      <= w_ok ? r_idx[dsfl_pkg::SLOT_W-1:0] : '0;
            o_handle_first  <= w_alloc_ok ? (r_cpu_base0 + w_prod_ext) : '0;
            o_handle_second <= (w_alloc_ok && r_heaps[1]) ? (r_cpu_base1 + w_prod_ext) : '0;
        end
    end

    dsfl_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_cmd.div_start),
        .i_dividend    (r_off[dsfl_pkg::SPAN_W-1:0]),
        .i_divisor     (r_stride),
        .o_done        (w_div_done),
        .o_quotient    (w_quotient),
        .o_rem_nonzero (w_rem_nonzero)
    );

endmodule

// ===== rtl/core/dsfl_ctrl.sv =====
// controller state machine sequencing allocate and free requests
module dsfl_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  dsfl_pkg::t_dp_stat i_stat,
    output dsfl_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_AMUL,
        S_AADD,
        S_SPAN,
        S_DIV,
        S_PUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = dsfl_pkg::ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                unique case (i_stat.req) inside
                    dsfl_pkg::REQ_ALLOC: begin
                        if (i_stat.exhausted) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = dsfl_pkg::ST_EXHAUSTED;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_AMUL;
                        end
                    end
                    dsfl_pkg::REQ_FREE_IDX: begin
                        if (i_stat.slot_none) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = dsfl_pkg::ST_NOOP;
                            n_state      = S_IDLE;
                        end else begin
                            n_state = S_PUSH;
                        end
                    end
                    dsfl_pkg::REQ_FREE_CPU, dsfl_pkg::REQ_FREE_GPU: begin
                        if (i_stat.two_heaps) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = dsfl_pkg::ST_TWO_HEAPS;
                            n_state      = S_IDLE;
                        end else if (i_stat.addr_zero) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = dsfl_pkg::ST_NOOP;
                            n_state      = S_IDLE;
                        end else if (i_stat.handle_bad) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = dsfl_pkg::ST_BAD_HANDLE;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.off_calc = 1'b1;
                            n_state        = S_SPAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_AMUL: begin
                o_cmd.alloc_take = 1'b1;
                n_state          = S_AADD;
            end
            S_AADD: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_SPAN: begin
                if (i_stat.over_span) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = dsfl_pkg::ST_BAD_HANDLE;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    if (i_stat.rem_nonzero) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = dsfl_pkg::ST_BAD_HANDLE;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.idx_from_div = 1'b1;
                        n_state            = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
                if (i_stat.idx_over) begin
                    o_cmd.status = dsfl_pkg::ST_RANGE;
                end else if (i_stat.count_zero) begin
                    o_cmd.status = dsfl_pkg::ST_EMPTY;
                end else begin
                    o_cmd.push = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;

endmodule

// ===== rtl/core/descriptor_slot_free_list_allocator.sv =====
// top level of the descriptor slot free-list allocator
// A request is taken when start is high and busy is low. Its single result beat shows on the
// o_ ports with o_done high for exactly one cycle and must be captured then: the receiver
// cannot stall. An allocate steps through the EVAL, AMUL and AADD states, a free by index
// through EVAL and PUSH, and a free by handle through EVAL, SPAN, DIV and PUSH, where DIV waits
// on the one-bit-per-cycle stride divider (17 steps). A refused allocate, a no-op free and a
// handle refused before the divide end in EVAL, a handle past the heap span in SPAN and a
// misaligned handle in DIV. busy is low while o_done is high, so a new request can be
// accepted at the edge that ends the o_done cycle. The free list needs no clearing pass.
module descriptor_slot_free_list_allocator #(
    parameter int MAX_SLOTS = 1024,
    parameter bit HEAP_PICK = 1'b0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [dsfl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dsfl_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [dsfl_pkg::REQ_W-1:0]     i_req_type,
    input  logic [dsfl_pkg::SLOT_W-1:0]    i_slot_in,
    input  logic                           i_slot_none,
    input  logic [dsfl_pkg::ADDR_W-1:0]    i_handle_addr,
    output logic [dsfl_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [dsfl_pkg::ADDR_W-1:0]    o_handle_first,
    output logic [dsfl_pkg::ADDR_W-1:0]    o_handle_second,
    output logic [dsfl_pkg::STATUS_W-1:0]  o_status,
    output logic                           o_done
);

    dsfl_pkg::t_dp_cmd  w_cmd;
    dsfl_pkg::t_dp_stat w_stat;

    dsfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    dsfl_datapath #(
        .MAX_SLOTS (MAX_SLOTS),
        .HEAP_PICK (HEAP_PICK)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_slot_in       (i_slot_in),
        .i_slot_none     (i_slot_none),
        .i_handle_addr   (i_handle_addr),
        .o_slot_out      (o_slot_out),
        .o_handle_first  (o_handle_first),
        .o_handle_second (o_handle_second),
        .o_status        (o_status),
        .o_done          (o_done)
    );

endmodule

// ===== sim/descriptor_slot_free_list_allocator_test.sv =====
// self-checking testbench for the descriptor slot free-list allocator: random and directed requests
module descriptor_slot_free_list_allocator_test;

    localparam int          SLOTS          = 1024;
    localparam int          SLOT_AW        = $clog2(SLOTS);
    localparam bit          HEAP_SEL       = 1'b0;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [dsfl_pkg::REQ_W-1:0]  req;
        logic [dsfl_pkg::SLOT_W-1:0] slot;
        logic                        none;
        logic [dsfl_pkg::ADDR_W-1:0] addr;
    } t_slot_req;

    typedef struct packed {
        logic [dsfl_pkg::SLOT_W-1:0] slot;
        logic [dsfl_pkg::ADDR_W-1:0] handle_first;
        logic [dsfl_pkg::ADDR_W-1:0] handle_second;
        dsfl_pkg::t_status           status;
    } t_slot_result;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           start         = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [dsfl_pkg::CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [dsfl_pkg::CFG_W-1:0]     i_cfg_data    = '0;
    logic [dsfl_pkg::REQ_W-1:0]     i_req_type    = '0;
    logic [dsfl_pkg::SLOT_W-1:0]    i_slot_in     = '0;
    logic                           i_slot_none   = 1'b0;
    logic [dsfl_pkg::ADDR_W-1:0]    i_handle_addr = '0;
    logic                           busy;
    logic [dsfl_pkg::SLOT_W-1:0]    o_slot_out;
    logic [dsfl_pkg::ADDR_W-1:0]    o_handle_first;
    logic [dsfl_pkg::ADDR_W-1:0]    o_handle_second;
    logic [dsfl_pkg::STATUS_W-1:0]  o_status;
    logic                           o_done;

    logic [dsfl_pkg::PERS_W-1:0]    cfg_persistent;
    logic [dsfl_pkg::TOTAL_W-1:0]   cfg_total;
    logic [dsfl_pkg::STRIDE_W-1:0]  cfg_stride;
    logic [dsfl_pkg::ADDR_W-1:0]    cfg_base0;
    logic [dsfl_pkg::ADDR_W-1:0]    cfg_base1;
    logic [dsfl_pkg::ADDR_W-1:0]    cfg_gpu_base;
    logic [dsfl_pkg::HEAPS_W-1:0]   cfg_heaps;
    logic [dsfl_pkg::SLOT_W-1:0]    free_stack [SLOTS];
    int unsigned                    alloc_depth;

    t_slot_req                      pending_reqs [$];
    t_slot_result                   expected_results [$];
    int unsigned                    idle_pct     = 0;
    int unsigned                    plan_depth   = 0;
    int unsigned                    quiet_cycles = 0;
    bit                             failed       = 1'b0;

    descriptor_slot_free_list_allocator #(
        .MAX_SLOTS(SLOTS),
        .HEAP_PICK(HEAP_SEL)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req_type(i_req_type),
        .i_slot_in(i_slot_in),
        .i_slot_none(i_slot_none),
        .i_handle_addr(i_handle_addr),
        .o_slot_out(o_slot_out),
        .o_handle_first(o_handle_first),
        .o_handle_second(o_handle_second),
        .o_status(o_status),
        .o_done(o_done)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned slot_limit();
        return (32'(cfg_persistent) < SLOTS) ? 32'(cfg_persistent) : SLOTS;
    endfunction

    function automatic dsfl_pkg::t_status release_slot(
        input  logic [dsfl_pkg::ADDR_W-1:0] idx,
        output logic [dsfl_pkg::SLOT_W-1:0] slot
    );
        slot = '0;
        if (idx >= dsfl_pkg::ADDR_W'(slot_limit()))
            return dsfl_pkg::ST_RANGE;
        if (alloc_depth == 0)
            return dsfl_pkg::ST_EMPTY;
        free_stack[SLOT_AW'(alloc_depth - 1)] = idx[dsfl_pkg::SLOT_W-1:0];
        alloc_depth--;
        slot = idx[dsfl_pkg::SLOT_W-1:0];
        return dsfl_pkg::ST_OK;
    endfunction

    function automatic t_slot_result predict_slot_result(input t_slot_req rq);
        t_slot_result                res;
        logic [dsfl_pkg::ADDR_W-1:0] base;
        logic [dsfl_pkg::ADDR_W-1:0] off;
        logic [dsfl_pkg::ADDR_W-1:0] span;
        logic [dsfl_pkg::ADDR_W-1:0] stride_ext;
        logic [dsfl_pkg::SLOT_W-1:0] slot;
        res = '0;
        res.status = dsfl_pkg::ST_OK;
        stride_ext = dsfl_pkg::ADDR_W'(cfg_stride);
        if (rq.req == dsfl_pkg::REQ_ALLOC) begin
            if (alloc_depth >= slot_limit()) begin
                res.status = dsfl_pkg::ST_EXHAUSTED;
            end else begin
                res.slot = free_stack[SLOT_AW'(alloc_depth)];
                alloc_depth++;
                res.handle_first = cfg_base0 + dsfl_pkg::ADDR_W'(res.slot) * stride_ext;
                if (cfg_heaps >= 2'd2)
                    res.handle_second = cfg_base1 + dsfl_pkg::ADDR_W'(res.slot) * stride_ext;
            end
        end else if (rq.req == dsfl_pkg::REQ_FREE_IDX) begin
            if (rq.none) begin
                res.status = dsfl_pkg::ST_NOOP;
            end else begin
                res.status = release_slot(dsfl_pkg::ADDR_W'(rq.slot), slot);
                res.slot = slot;
            end
        end else begin
            base = (rq.req == dsfl_pkg::REQ_FREE_GPU) ? cfg_gpu_base :
                   (HEAP_SEL ? cfg_base1 : cfg_base0);
            if (cfg_heaps >= 2'd2) begin
                res.status = dsfl_pkg::ST_TWO_HEAPS;
            end else if (rq.addr == '0) begin
                res.status = dsfl_pkg::ST_NOOP;
            end else if (cfg_stride == '0 || rq.addr < base) begin
                res.status = dsfl_pkg::ST_BAD_HANDLE;
            end else begin
                off = rq.addr - base;
                span = stride_ext * dsfl_pkg::ADDR_W'(cfg_total);
                if (off >= span || (off % stride_ext) != '0) begin
                    res.status = dsfl_pkg::ST_BAD_HANDLE;
                end else begin
                    res.status = release_slot(off / stride_ext, slot);
                    res.slot = slot;
                end
            end
        end
        return res;
    endfunction

    // mostly well-formed allocate/free traffic, steered by a rough guess of the stack depth
    function automatic t_slot_req random_request(input int unsigned alloc_pct);
        t_slot_req                   rq;
        int unsigned                 lim;
        int unsigned                 k;
        int unsigned                 pct;
        logic [dsfl_pkg::ADDR_W-1:0] base;
        logic [dsfl_pkg::ADDR_W-1:0] stride_ext;
        logic [dsfl_pkg::ADDR_W-1:0] skew;
        lim = slot_limit();
        stride_ext = dsfl_pkg::ADDR_W'(cfg_stride);
        rq.req = dsfl_pkg::REQ_ALLOC;
        rq.slot = dsfl_pkg::SLOT_W'($urandom);
        rq.none = 1'($urandom_range(1));
        rq.addr = {$urandom, $urandom};
        pct = (plan_depth == 0) ? 75 : (plan_depth >= lim) ? 20 : alloc_pct;
        if ($urandom_range(99) < pct) begin
            if (plan_depth < lim)
                plan_depth++;
            return rq;
        end
        k = $urandom_range(lim + 2);
        rq.req = ($urandom_range(1) != 0) ? dsfl_pkg::REQ_FREE_CPU : dsfl_pkg::REQ_FREE_GPU;
        base = (rq.req == dsfl_pkg::REQ_FREE_GPU) ? cfg_gpu_base :
               (HEAP_SEL ? cfg_base1 : cfg_base0);
        case ($urandom_range(9))
            0, 1, 2: begin
                rq.req = dsfl_pkg::REQ_FREE_IDX;
                rq.slot = dsfl_pkg::SLOT_W'(k);
                rq.none = ($urandom_range(19) == 0);
                if (!rq.none && k < lim && plan_depth > 0)
                    plan_depth--;
            end
            3, 4, 5, 6: begin
                rq.addr = base + dsfl_pkg::ADDR_W'(k) * stride_ext;
                if (k < lim && cfg_heaps < 2'd2 && plan_depth > 0)
                    plan_depth--;
            end
            7: begin
                case ($urandom_range(3))
                    0: rq.addr = '0;
                    1: begin
                        skew = (cfg_stride > 1) ?
                               dsfl_pkg::ADDR_W'($urandom_range(32'(cfg_stride) - 1, 1)) :
                               dsfl_pkg::ADDR_W'(1);
                        rq.addr = base + dsfl_pkg::ADDR_W'(k) * stride_ext + skew;
                    end
                    2: rq.addr = base - dsfl_pkg::ADDR_W'($urandom_range(4096, 1));
                    default: rq.addr = base + stride_ext * dsfl_pkg::ADDR_W'(cfg_total)
                                       + dsfl_pkg::ADDR_W'(k) * stride_ext;
                endcase
            end
            8: begin
                rq.req = dsfl_pkg::REQ_FREE_IDX;
                rq.none = 1'b0;
            end
            default: begin
                rq.req = dsfl_pkg::REQ_W'($urandom_range(3, 1));
            end
        endcase
        return rq;
    endfunction

    task automatic add_req(input logic [dsfl_pkg::REQ_W-1:0] req,
                           input logic [dsfl_pkg::SLOT_W-1:0] slot,
                           input logic none, input logic [dsfl_pkg::ADDR_W-1:0] addr);
        pending_reqs.push_back({req, slot, none, addr});
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || start || busy || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [dsfl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dsfl_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            dsfl_pkg::CFG_PERSISTENT: cfg_persistent = val[dsfl_pkg::PERS_W-1:0];
            dsfl_pkg::CFG_TOTAL:      cfg_total = val[dsfl_pkg::TOTAL_W-1:0];
            dsfl_pkg::CFG_STRIDE:     cfg_stride = val[dsfl_pkg::STRIDE_W-1:0];
            dsfl_pkg::CFG_CPU_BASE0:  cfg_base0 = val;
            dsfl_pkg::CFG_CPU_BASE1:  cfg_base1 = val;
            dsfl_pkg::CFG_GPU_BASE:   cfg_gpu_base = val;
            dsfl_pkg::CFG_HEAPS:      cfg_heaps = val[dsfl_pkg::HEAPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [dsfl_pkg::CFG_W-1:0] pers,
                              input logic [dsfl_pkg::CFG_W-1:0] total,
                              input logic [dsfl_pkg::CFG_W-1:0] stride,
                              input logic [dsfl_pkg::CFG_W-1:0] base0,
                              input logic [dsfl_pkg::CFG_W-1:0] base1,
                              input logic [dsfl_pkg::CFG_W-1:0] gpu,
                              input logic [dsfl_pkg::CFG_W-1:0] heaps);
        write_reg(dsfl_pkg::CFG_PERSISTENT, pers);
        write_reg(dsfl_pkg::CFG_TOTAL, total);
        write_reg(dsfl_pkg::CFG_STRIDE, stride);
        write_reg(dsfl_pkg::CFG_CPU_BASE0, base0);
        write_reg(dsfl_pkg::CFG_CPU_BASE1, base1);
        write_reg(dsfl_pkg::CFG_GPU_BASE, gpu);
        write_reg(dsfl_pkg::CFG_HEAPS, heaps);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int unsigned pct_idle, input int unsigned count,
                             input int unsigned alloc_pct);
        idle_pct = pct_idle;
        repeat (count)
            pending_reqs.push_back(random_request(alloc_pct));
        wait_idle();
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_slot_req nxt;
        t_slot_req seen;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                seen = {i_req_type, i_slot_in, i_slot_none, i_handle_addr};
                expected_results.push_back(predict_slot_result(seen));
            end
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = pending_reqs.pop_front();
                start <= 1'b1;
                i_req_type <= nxt.req;
                i_slot_in <= nxt.slot;
                i_slot_none <= nxt.none;
                i_handle_addr <= nxt.addr;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_slot_result want;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, slot %0d status %0d",
                         $time, o_slot_out, o_status);
                failed = 1'b1;
            end else begin
                want = expected_results.pop_front();
                check_field("slot_out", 64'(want.slot), 64'(o_slot_out));
                check_field("handle_first", want.handle_first, o_handle_first);
                check_field("handle_second", want.handle_second, o_handle_second);
                check_field("status", 64'(want.status), 64'(o_status));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("descriptor_slot_free_list_allocator_test NOT OK");
        $finish;
    end

    initial begin
        cfg_persistent = 11'd1024;
        cfg_total = 17'd1024;
        cfg_stride = 13'd32;
        cfg_base0 = '0;
        cfg_base1 = '0;
        cfg_gpu_base = '0;
        cfg_heaps = 2'd1;
        alloc_depth = 0;
        for (int i = 0; i < SLOTS; i++)
            free_stack[SLOT_AW'(i)] = dsfl_pkg::SLOT_W'(i);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 38;
        add_req(dsfl_pkg::REQ_FREE_IDX, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_IDX, 10'd0, 1'b1, '0);
        add_req(dsfl_pkg::REQ_FREE_IDX, 10'd1023, 1'b0, '0);
        add_req(dsfl_pkg::REQ_ALLOC, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_ALLOC, 10'd1023, 1'b1, '1);
        add_req(dsfl_pkg::REQ_FREE_CPU, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_CPU, 10'd0, 1'b0, 64'd32);
        add_req(dsfl_pkg::REQ_FREE_GPU, 10'd0, 1'b0, 64'd33);
        add_req(dsfl_pkg::REQ_FREE_GPU, 10'd0, 1'b0, 64'd32768);
        add_req(dsfl_pkg::REQ_FREE_CPU, 10'd0, 1'b0, '1);
        add_req(dsfl_pkg::REQ_FREE_IDX, 10'd1023, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_IDX, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_ALLOC, 10'd0, 1'b0, '0);
        wait_idle();

        set_config(2, 4, 16, 64'h1000, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000, 1);
        add_req(dsfl_pkg::REQ_ALLOC, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_ALLOC, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_CPU, 10'd0, 1'b0, 64'h1020);
        add_req(dsfl_pkg::REQ_FREE_GPU, 10'd0, 1'b0, 64'h7FF0);
        add_req(dsfl_pkg::REQ_FREE_GPU, 10'd0, 1'b0, 64'h8040);
        add_req(dsfl_pkg::REQ_FREE_IDX, 10'd5, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_CPU, 10'd0, 1'b0, 64'h1010);
        add_req(dsfl_pkg::REQ_FREE_IDX, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_IDX, 10'd1, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_IDX, 10'd1023, 1'b0, '0);
        wait_idle();
        set_config(2, 4, 16, 64'h1000, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000, 2);
        add_req(dsfl_pkg::REQ_ALLOC, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_CPU, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_GPU, 10'd0, 1'b0, 64'h8010);
        wait_idle();
        set_config(2, 4, 16, 64'h1000, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000, 0);
        add_req(dsfl_pkg::REQ_ALLOC, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_GPU, 10'd0, 1'b0, 64'h8000);
        wait_idle();
        set_config(2, 4, 16, 64'h1000, 64'hFFFF_FFFF_FFFF_FFF0, 64'h8000, 3);
        add_req(dsfl_pkg::REQ_ALLOC, 10'd0, 1'b0, '0);
        wait_idle();
        set_config(2, 4, 0, 64'h1000, 64'h2000, 64'h8000, 1);
        add_req(dsfl_pkg::REQ_ALLOC, 10'd0, 1'b0, '0);
        add_req(dsfl_pkg::REQ_FREE_CPU, 10'd0, 1'b0, 64'h1000);
        wait_idle();

        plan_depth = alloc_depth;
        set_config(1024, 1024, 32, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, 1);
        run_phase(38, 200, 60);
        set_config(1, 1, 1, '0, '0, '0, 1);
        run_phase(38, 120, 50);
        set_config(2047, 65536, 4096, 64'hFFFF_FFFF_FFFF_F000, '1,
                   64'hFFFF_FFFF_FF00_0000, 1);
        run_phase(38, 200, 55);
        set_config(300, 400, 64'($urandom_range(4096, 1)), {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, 1);
        run_phase(73, 200, 85);
        set_config(16, 16, 64'($urandom_range(4096, 1)), {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, 2);
        run_phase(73, 150, 50);
        set_config(64, 128, 64'($urandom_range(4096, 1)), {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, 3);
        run_phase(73, 150, 50);
        set_config(32, 40, 64'($urandom_range(4096, 1)), {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, 0);
        run_phase(73, 150, 50);
        set_config(8, 65536, 0, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, 1);
        run_phase(0, 100, 50);
        set_config(64'($urandom_range(1024, 1)), 64'($urandom_range(65536, 1)),
                   64'($urandom_range(4096, 1)), {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, 1);
        run_phase(0, 200, 55);
        set_config(1024, 1, 1, '1, '0, '1, 1);
        run_phase(0, 200, 45);

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failed)
            $display("descriptor_slot_free_list_allocator_test NOT OK");
        else
            $display("descriptor_slot_free_list_allocator_test OK");
        $finish;
    end

endmodule

// ===== descriptor_slot_free_list_allocator.f =====
rtl/core/dsfl_pkg.sv
rtl/core/dsfl_div.sv
rtl/core/dsfl_datapath.sv
rtl/core/dsfl_ctrl.sv
rtl/core/descriptor_slot_free_list_allocator.sv
sim/descriptor_slot_free_list_allocator_test.sv
